[rtl/mpfb_pkg.sv]
// Package for the meter payment frame builder: frame layout constants,
// the beat type carried by the shift cells, the frame builder and the CRC step.
// No dependencies.
package mpfb_pkg;

    localparam int FrameLen  = 45;
    localparam int CrcFirst  = 13;
    localparam int CrcLast   = 41;
    localparam int CrcLoPos  = 42;
    localparam int CrcHiPos  = 43;
    localparam int PosW      = $clog2(FrameLen + 1);

    localparam logic [7:0]  TypeWord  = 8'd102;
    localparam logic [7:0]  LenWord   = 8'h20;
    localparam logic [7:0]  StartMark = 8'h68;
    localparam logic [7:0]  EndMark   = 8'h16;
    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'hA001;

    localparam logic [0:0]  RegLinkUp = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       refused;
    } beat_t;

    typedef logic [FrameLen-1:0][7:0] frame_t;

    function automatic frame_t build_frame(input logic [31:0] dtu, input logic [7:0] mid,
                                           input logic [23:0] pay, input logic [31:0] dly);
        frame_t f;
        f      = '0;
        f[0]   = TypeWord;
        f[4]   = LenWord;
        f[8]   = dtu[7:0];
        f[9]   = dtu[15:8];
        f[10]  = dtu[23:16];
        f[11]  = dtu[31:24];
        f[12]  = mid;
        f[13]  = StartMark;
        f[14]  = mid;
        f[15]  = 8'h20;
        f[16]  = 8'h04;
        f[17]  = 8'h08;
        f[18]  = pay[7:0];
        f[19]  = pay[15:8];
        f[20]  = pay[23:16];
        f[21]  = dly[7:0];
        f[22]  = dly[15:8];
        f[23]  = dly[23:16];
        f[24]  = dly[31:24];
        f[25]  = 8'h06;
        f[27]  = 8'h04;
        f[28]  = 8'h46;
        f[31]  = 8'h32;
        f[44]  = EndMark;
        return f;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/meter_payment_frame_builder_core.sv]
// Meter payment frame builder top level: holding register, 45-cell shift chain, CRC unit.
// A command is registered in the holding register, then loaded into the chain; bytes
// leave one per cycle while m_ready is high, one cell per beat; a refusal is one beat.
// A held command loads the chain as its last byte leaves, so frames run back to back.
// Synchronous active-low reset empties the chain and holding register, link_up clears to 0.
// Depends on mpfb_pkg, mpfb_cell, mpfb_crc.
module meter_payment_frame_builder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_dtu_id,
    input  logic [7:0]  s_meter_id,
    input  logic [23:0] s_payment,
    input  logic [31:0] s_delay_tenths,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_last_byte,
    output logic        m_refused
);
    import mpfb_pkg::*;

    logic              link_up_reg;
    logic              hold_valid_reg;
    logic              hold_refused_reg;
    logic [31:0]       hold_dtu_reg;
    logic [7:0]        hold_mid_reg;
    logic [23:0]       hold_pay_reg;
    logic [31:0]       hold_dly_reg;
    logic [PosW-1:0]   count_reg;
    logic [PosW-1:0]   count_next;
    logic [PosW-1:0]   pos_reg;
    logic [PosW-1:0]   pos_next;

    logic              s_take;
    logic              m_take;
    logic              load;
    logic              crc_upd;
    logic [15:0]       crc;
    frame_t            frame;
    beat_t             load_beats [FrameLen];
    beat_t             cell_beats [FrameLen+1];
    beat_t             head;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == RegLinkUp) ? {31'd0, link_up_reg} : 32'd0;

    assign s_ready = !hold_valid_reg;
    assign s_take  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_take  = m_valid && m_ready;
    assign load    = hold_valid_reg
                     && ((count_reg == '0) || ((count_reg == PosW'(1)) && m_ready));

    assign frame = build_frame(hold_dtu_reg, hold_mid_reg, hold_pay_reg, hold_dly_reg);

    always_comb begin
        for (int i = 0; i < FrameLen; i++) begin
            if (hold_refused_reg) begin
                load_beats[i] = '{data: 8'h00, last: (i == 0), refused: (i == 0)};
            end else begin
                load_beats[i] = '{data: frame[i], last: (i == FrameLen - 1), refused: 1'b0};
            end
        end
    end

    assign cell_beats[FrameLen] = '0;

    for (genvar g = 0; g < FrameLen; g++) begin : g_cell
        mpfb_cell u_cell (
            .aclk      (aclk),
            .load      (load),
            .shift     (m_take),
            .load_beat (load_beats[g]),
            .next_beat (cell_beats[g+1]),
            .beat      (cell_beats[g])
        );
    end

    assign head = cell_beats[0];

    assign crc_upd = m_take && !head.refused
                     && (pos_reg >= PosW'(CrcFirst)) && (pos_reg <= PosW'(CrcLast));

    mpfb_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (load),
        .update  (crc_upd),
        .data    (head.data),
        .crc     (crc)
    );

    always_comb begin
        m_frame_byte = head.data;
        if (!head.refused && (pos_reg == PosW'(CrcLoPos))) begin
            m_frame_byte = crc[7:0];
        end else if (!head.refused && (pos_reg == PosW'(CrcHiPos))) begin
            m_frame_byte = crc[15:8];
        end
    end
    assign m_last_byte = head.last;
    assign m_refused   = head.refused;

    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        if (load) begin
            count_next = hold_refused_reg ? PosW'(1) : PosW'(FrameLen);
            pos_next   = '0;
        end else if (m_take) begin
            count_next = count_reg - PosW'(1);
            pos_next   = pos_reg + PosW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_up_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= '0;
        end else begin
            if (psel && penable && pwrite && (paddr[2:2] == RegLinkUp)) begin
                link_up_reg <= pwdata[0];
            end
            if (s_take) begin
                hold_valid_reg <= 1'b1;
            end else if (load) begin
                hold_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            hold_refused_reg <= !link_up_reg;
            hold_dtu_reg     <= s_dtu_id;
            hold_mid_reg     <= s_meter_id;
            hold_pay_reg     <= s_payment;
            hold_dly_reg     <= s_delay_tenths;
        end
    end

endmodule

[rtl/mpfb_cell.sv]
// One cell of the frame shift chain: holds one beat, loads in parallel or
// takes its neighbour's beat on a shift. Depends on mpfb_pkg.
module mpfb_cell (
    input  logic           aclk,
    input  logic           load,
    input  logic           shift,
    input  mpfb_pkg::beat_t load_beat,
    input  mpfb_pkg::beat_t next_beat,
    output mpfb_pkg::beat_t beat
);
    import mpfb_pkg::*;

    beat_t beat_reg;
    beat_t beat_next;

    always_comb begin
        beat_next = beat_reg;
        if (load) begin
            beat_next = load_beat;
        end else if (shift) begin
            beat_next = next_beat;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign beat = beat_reg;

endmodule

[rtl/mpfb_crc.sv]
// CRC-16/Modbus accumulator fed one byte per beat from the chain head.
// Depends on mpfb_pkg.
module mpfb_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        init,
    input  logic        update,
    input  logic [7:0]  data,
    output logic [15:0] crc
);
    import mpfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (init) begin
            crc_next = CrcInit;
        end else if (update) begin
            crc_next = crc_step(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CrcInit;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

[test/meter_payment_frame_builder_core_test.sv]
// Testbench for meter_payment_frame_builder_core: drives payment commands and link_up writes,
// predicts each 45-byte frame (Modbus CRC included) or refusal beat and checks the byte stream.
// Depends on mpfb_pkg and the core RTL.
module meter_payment_frame_builder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpfb_pkg::*;

    localparam int         QuietLimit = 2000;
    localparam int         SpareReg   = 1;
    localparam logic [2:0] LinkAddr   = 3'(4 * RegLinkUp);
    localparam logic [2:0] SpareAddr  = 3'(4 * SpareReg);

    class frame_scoreboard;
        beat_t awaited_bytes[$];
        bit    link;
        int    errors;
        int    checked;
        int    frames;
        int    refusals;

        function new();
            link = 1'b0;
        endfunction

        function void config_write(input int index, input logic [31:0] value);
            if (index == RegLinkUp) link = value[0];
        endfunction

        function logic [15:0] modbus_byte(input logic [15:0] crc,
                                          input logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            repeat (8) c = (c >> 1) ^ (c[0] ? 16'hA001 : 16'h0000);
            return c;
        endfunction

        function void note_command(input logic [31:0] dtu, input logic [7:0] mid,
                                   input logic [23:0] pay, input logic [31:0] dly);
            logic [7:0]  fr [FrameLen];
            logic [15:0] crc;
            beat_t       b;
            if (!link) begin
                b = '{data: 8'h00, last: 1'b1, refused: 1'b1};
                awaited_bytes.push_back(b);
                refusals++;
                return;
            end
            foreach (fr[i]) fr[i] = 8'h00;
            {fr[3], fr[2], fr[1], fr[0]}     = 32'd102;
            {fr[7], fr[6], fr[5], fr[4]}     = 32'd32;
            {fr[11], fr[10], fr[9], fr[8]}   = dtu;
            fr[12] = mid;
            fr[13] = 8'h68;
            fr[14] = mid;
            fr[15] = 8'h20;
            fr[16] = 8'h04;
            fr[17] = 8'h08;
            {fr[20], fr[19], fr[18]}         = pay;
            {fr[24], fr[23], fr[22], fr[21]} = dly;
            fr[25] = 8'h06;
            fr[27] = 8'h04;
            fr[28] = 8'h46;
            fr[31] = 8'h32;
            crc = 16'hFFFF;
            for (int i = 13; i <= 41; i++) crc = modbus_byte(crc, fr[i]);
            {fr[43], fr[42]} = crc;
            fr[44] = 8'h16;
            for (int i = 0; i < FrameLen; i++) begin
                b = '{data: fr[i], last: (i == FrameLen - 1), refused: 1'b0};
                awaited_bytes.push_back(b);
            end
            frames++;
        endfunction

        task flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
            errors++;
            if (errors <= 25)
                $display("%0t mismatch on %s at beat %0d: expected %0h, got %0h",
                         $realtime, what, checked, want, got);
        endtask

        task check_beat(input logic [7:0] data, input logic last, input logic refused);
            beat_t want;
            if (awaited_bytes.size() == 0) begin
                flag_mismatch("unexpected beat", 32'd0, 32'(data));
                return;
            end
            want = awaited_bytes.pop_front();
            if (data !== want.data) flag_mismatch("frame_byte", 32'(want.data), 32'(data));
            if (last !== want.last) flag_mismatch("last_byte", 32'(want.last), 32'(last));
            if (refused !== want.refused)
                flag_mismatch("refused", 32'(want.refused), 32'(refused));
            checked++;
        endtask

        task check_drained();
            if (awaited_bytes.size() != 0)
                flag_mismatch("beats never delivered", 32'(awaited_bytes.size()), 32'd0);
        endtask
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_dtu_id       = '0;
    logic [7:0]  s_meter_id     = '0;
    logic [23:0] s_payment      = '0;
    logic [31:0] s_delay_tenths = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_last_byte;
    logic        m_refused;

    frame_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int commands       = 0;

    meter_payment_frame_builder_core uut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_beat(m_frame_byte, m_last_byte, m_refused);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t watchdog: no beat for %0d cycles", $realtime, QuietLimit);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.config_write(int'(addr >> 2), data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_command(input logic [31:0] dtu, input logic [7:0] mid,
                                input logic [23:0] pay, input logic [31:0] dly,
                                input bit hold);
        while (hold && sb.awaited_bytes.size() != 0) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_dtu_id       <= dtu;
        s_meter_id     <= mid;
        s_payment      <= pay;
        s_delay_tenths <= dly;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(dtu, mid, pay, dly);
        commands++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.awaited_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++)
            send_command(pick_value(), 8'(pick_value()), 24'(pick_value()), pick_value(),
                         (k % 15 == 14));
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // link down out of reset: refusals only
        send_command(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_command(32'h0, 8'h00, 24'h0, 32'h0, 1'b0);
        wait_drained();
        apb_write(SpareAddr, 32'h1);
        send_command(32'h1234_5678, 8'h5A, 24'h12_3456, 32'h0000_0064, 1'b0);
        wait_drained();
        apb_write(LinkAddr, 32'hFFFF_FFFF);

        send_command(32'h0, 8'h00, 24'h0, 32'h0, 1'b0);
        send_command(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_command(32'hAAAA_AAAA, 8'hAA, 24'hAA_AAAA, 32'hAAAA_AAAA, 1'b0);
        send_command(32'h5555_5555, 8'h55, 24'h55_5555, 32'h5555_5555, 1'b0);
        send_command(32'hFFFF_FFFF, 8'h00, 24'h0, 32'h0, 1'b0);
        send_command(32'h0, 8'hFF, 24'hFF_FFFF, 32'h0, 1'b0);
        send_command(32'h0000_0001, 8'h01, 24'h00_0001, 32'h8000_0000, 1'b0);
        send_command(32'h8000_0000, 8'h80, 24'h80_0000, 32'h0000_0001, 1'b0);
        wait_drained();
        apb_write(LinkAddr, 32'hFFFF_FFFE);
        send_command(32'h0BAD_F00D, 8'h42, 24'h00_1000, 32'h0000_000A, 1'b0);
        wait_drained();
        apb_write(LinkAddr, 32'h0000_0001);
        send_command(32'h0BAD_F00D, 8'h42, 24'h00_1000, 32'h0000_000A, 1'b0);
        wait_drained();

        run_phase(40, 0, 0);
        run_phase(40, 46, 0);
        apb_write(LinkAddr, 32'h0);
        run_phase(16, 0, 46);
        apb_write(LinkAddr, 32'h1);
        run_phase(40, 0, 46);
        run_phase(40, 32, 32);

        repeat (60) @(posedge aclk);
        sb.check_drained();
        $display("%0d commands sent: %0d frames and %0d refusals, %0d beats checked",
                 commands, sb.frames, sb.refusals, sb.checked);
        $display("link toggled both ways, with sender gaps and receiver stalls in turn");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
